// ----- rtl/iucheck_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/UDP receive checker package
// Beat types, verdict codes, protocol constants and one's-complement add.
// ----------------------------------------------------------------------------
package iucheck_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

    localparam logic [15:0] SUM_ALL_ONES    = 16'hFFFF;
    localparam logic [15:0] UDP_PROTO_NUM   = 16'd17;
    localparam int unsigned MIN_IP_HDR      = 20;
    localparam int unsigned UDP_HDR_BYTES   = 8;
    localparam int unsigned PSEUDO_FIRST    = 12;
    localparam int unsigned PSEUDO_END      = 20;
    localparam int unsigned SRC_END         = 16;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_HDR_LEN      = 3'd2,
        ST_UDP_SMALL    = 3'd3,
        ST_UDP_OVERFLOW = 3'd4,
        ST_IP_CSUM      = 3'd5,
        ST_UDP_CSUM     = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       csum_check_en;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [6:0]  payload_offset;
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [15:0] source_port;
    } t_out;

    // End-around-carry add; matches a running sum kept in 0..FFFF.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ----- rtl/ipv4_udp_receive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/UDP receive checker
// Streams an IPv4 packet a byte per beat and gives one verdict per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle while o_in_ready is high,
// starting at the IPv4 version/IHL byte, and gives exactly one verdict
// beat for the beat marked last_byte. Every byte is folded into running
// one's-complement sums (IPv4 header, and UDP pseudo-header/header/payload)
// as it arrives, so there is no buffering and a new byte can be taken
// right after a last byte. The last byte's final sums and lengths go into
// the snapshot stage; the length checks and the UDP checksum close-out run
// from there into the output register. Input ready drops only when both
// the snapshot stage and the output register hold a verdict that the sink
// has not taken. Checks run in order: fewer than 20 bytes, bad header/total
// length, UDP length below 8, UDP overflow, IPv4 checksum, then UDP
// checksum (only when the UDP checksum field is nonzero and csum_check_en
// is set on the last byte). On any failure only status is meaningful and
// the other fields read zero. Bytes past MAX_PACKET_BYTES are dropped from
// the sums, but a last mark there still closes the packet.
module ipv4_udp_receive_checker #(
    parameter int unsigned MAX_PACKET_BYTES = iucheck_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iucheck_pkg::t_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output iucheck_pkg::t_out o_out_data
);

    localparam int unsigned PW   = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned CmpW = 17;

    // UDP header byte offsets
    localparam logic [2:0] OFF_SPORT_HI = 3'd0;
    localparam logic [2:0] OFF_SPORT_LO = 3'd1;
    localparam logic [2:0] OFF_ULEN_HI  = 3'd4;
    localparam logic [2:0] OFF_ULEN_LO  = 3'd5;
    localparam logic [2:0] OFF_CSUM_HI  = 3'd6;
    localparam logic [2:0] OFF_CSUM_LO  = 3'd7;

    // ------------------------------------------------------------------
    // Running packet state
    // ------------------------------------------------------------------
    logic [PW-1:0] r_pos,     n_pos;
    logic [5:0]    r_hl,      n_hl;
    logic [15:0]   r_tl,      n_tl;
    logic [15:0]   r_ul,      n_ul;
    logic [15:0]   r_hsum,    n_hsum;
    logic [15:0]   r_usum,    n_usum;
    logic [7:0]    r_pend,    n_pend;
    logic [31:0]   r_src,     n_src;
    logic [15:0]   r_port,    n_port;
    logic [15:0]   r_ucheck,  n_ucheck;

    // Snapshot stage (final state of one packet)
    logic          r_snap_valid;
    logic [PW-1:0] r_snap_len;
    logic [5:0]    r_snap_hl;
    logic [15:0]   r_snap_tl;
    logic [15:0]   r_snap_ul;
    logic [15:0]   r_snap_hsum;
    logic [15:0]   r_snap_usum;
    logic [31:0]   r_snap_src;
    logic [15:0]   r_snap_port;
    logic [15:0]   r_snap_ucheck;
    logic          r_snap_cready;

    // Output register
    logic              r_out_valid;
    iucheck_pkg::t_out r_out;

    logic in_acc, out_free, snap_adv, take;
    logic [7:0]      b;
    logic [CmpW-1:0] w_pos, w_hl;
    logic [2:0]      w_off;
    logic [15:0]     w_part, w_sum1;
    logic            pseudo, uhdr, udata;

    assign out_free   = !r_out_valid || i_out_ready;
    assign snap_adv   = r_snap_valid && out_free;
    // Registered-only ready: with the output register empty the snapshot
    // drains this cycle, so a new last byte can always land.
    assign o_in_ready = !r_snap_valid || !r_out_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign b          = i_in_data.data_byte;

    // ------------------------------------------------------------------
    // Per-byte update
    // ------------------------------------------------------------------
    always_comb begin
        n_pos    = r_pos;
        n_hl     = r_hl;
        n_tl     = r_tl;
        n_ul     = r_ul;
        n_hsum   = r_hsum;
        n_usum   = r_usum;
        n_pend   = r_pend;
        n_src    = r_src;
        n_port   = r_port;
        n_ucheck = r_ucheck;

        take   = r_pos < PW'(MAX_PACKET_BYTES);
        w_pos  = CmpW'(r_pos);
        // IHL is used on the very byte that carries it
        n_hl   = (r_pos == '0) ? {b[3:0], 2'b00} : r_hl;
        w_hl   = CmpW'(n_hl);
        w_off  = 3'(w_pos - w_hl);
        w_part = r_pos[0] ? {8'd0, b} : {b, 8'd0};

        pseudo = (w_pos >= CmpW'(iucheck_pkg::PSEUDO_FIRST))
              && (w_pos <  CmpW'(iucheck_pkg::PSEUDO_END));
        uhdr   = (w_pos >= w_hl)
              && (w_pos <  w_hl + CmpW'(iucheck_pkg::UDP_HDR_BYTES));
        udata  = (w_pos >= w_hl + CmpW'(iucheck_pkg::UDP_HDR_BYTES))
              && (w_pos <  w_hl + CmpW'(r_ul));

        w_sum1 = pseudo ? iucheck_pkg::ones_add(r_usum, w_part) : r_usum;

        if (take) begin
            n_pos = r_pos + PW'(1);

            if (w_pos == CmpW'(2)) begin
                n_tl[15:8] = b;
            end
            if (w_pos == CmpW'(3)) begin
                n_tl[7:0] = b;
            end
            if (w_pos >= CmpW'(iucheck_pkg::PSEUDO_FIRST)
                    && w_pos < CmpW'(iucheck_pkg::SRC_END)) begin
                n_src = {r_src[23:0], b};
            end

            // Pair header bytes into words for the header sum
            if (w_pos < w_hl) begin
                if (!r_pos[0]) begin
                    n_pend = b;
                end else begin
                    n_hsum = iucheck_pkg::ones_add(r_hsum, {r_pend, b});
                end
            end

            // A byte in both roles counts in both terms
            n_usum = (uhdr || udata) ? iucheck_pkg::ones_add(w_sum1, w_part) : w_sum1;

            if (uhdr) begin
                case (w_off)
                    OFF_SPORT_HI: n_port[15:8]   = b;
                    OFF_SPORT_LO: n_port[7:0]    = b;
                    OFF_ULEN_HI:  n_ul[15:8]     = b;
                    OFF_ULEN_LO:  n_ul[7:0]      = b;
                    OFF_CSUM_HI:  n_ucheck[15:8] = b;
                    OFF_CSUM_LO:  n_ucheck[7:0]  = b;
                    default:      n_ul           = n_ul;
                endcase
            end
        end else begin
            // Past the size limit: drop the byte, keep everything
            n_hl   = r_hl;
            n_usum = r_usum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hl     <= '0;
            r_tl     <= '0;
            r_ul     <= '0;
            r_hsum   <= '0;
            r_usum   <= '0;
            r_pend   <= '0;
            r_src    <= '0;
            r_port   <= '0;
            r_ucheck <= '0;
        end else if (in_acc) begin
            if (i_in_data.last_byte) begin
                // Clear for the next packet
                r_pos    <= '0;
                r_hl     <= '0;
                r_tl     <= '0;
                r_ul     <= '0;
                r_hsum   <= '0;
                r_usum   <= '0;
                r_pend   <= '0;
                r_src    <= '0;
                r_port   <= '0;
                r_ucheck <= '0;
            end else begin
                r_pos    <= n_pos;
                r_hl     <= n_hl;
                r_tl     <= n_tl;
                r_ul     <= n_ul;
                r_hsum   <= n_hsum;
                r_usum   <= n_usum;
                r_pend   <= n_pend;
                r_src    <= n_src;
                r_port   <= n_port;
                r_ucheck <= n_ucheck;
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot stage: capture the final state on the last byte
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (snap_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            r_snap_len    <= n_pos;
            r_snap_hl     <= n_hl;
            r_snap_tl     <= n_tl;
            r_snap_ul     <= n_ul;
            r_snap_hsum   <= n_hsum;
            r_snap_usum   <= n_usum;
            r_snap_src    <= n_src;
            r_snap_port   <= n_port;
            r_snap_ucheck <= n_ucheck;
            r_snap_cready <= i_in_data.csum_check_en;
        end
    end

    // ------------------------------------------------------------------
    // Verdict
    // ------------------------------------------------------------------
    logic [CmpW-1:0]     v_len, v_hl, v_tl, v_ul;
    logic [15:0]         v_ufinal;
    iucheck_pkg::t_status v_status;
    iucheck_pkg::t_out   n_out;

    always_comb begin
        v_len    = CmpW'(r_snap_len);
        v_hl     = CmpW'(r_snap_hl);
        v_tl     = CmpW'(r_snap_tl);
        v_ul     = CmpW'(r_snap_ul);
        // Close the UDP sum with the protocol and length pseudo-header terms
        v_ufinal = iucheck_pkg::ones_add(
                       iucheck_pkg::ones_add(r_snap_usum, iucheck_pkg::UDP_PROTO_NUM),
                       r_snap_ul);

        if (v_len < CmpW'(iucheck_pkg::MIN_IP_HDR)) begin
            v_status = iucheck_pkg::ST_SHORT;
        end else if (v_hl > v_len || v_tl > v_len
                     || v_hl + CmpW'(iucheck_pkg::UDP_HDR_BYTES) > v_len) begin
            v_status = iucheck_pkg::ST_HDR_LEN;
        end else if (v_ul < CmpW'(iucheck_pkg::UDP_HDR_BYTES)) begin
            v_status = iucheck_pkg::ST_UDP_SMALL;
        end else if (v_hl + v_ul > v_len) begin
            v_status = iucheck_pkg::ST_UDP_OVERFLOW;
        end else if (r_snap_hsum != iucheck_pkg::SUM_ALL_ONES) begin
            v_status = iucheck_pkg::ST_IP_CSUM;
        end else if (r_snap_ucheck != 16'd0 && r_snap_cready
                     && v_ufinal != iucheck_pkg::SUM_ALL_ONES) begin
            v_status = iucheck_pkg::ST_UDP_CSUM;
        end else begin
            v_status = iucheck_pkg::ST_OK;
        end

        n_out        = '0;
        n_out.status = v_status;
        if (v_status == iucheck_pkg::ST_OK) begin
            n_out.payload_offset = 7'(r_snap_hl) + 7'(iucheck_pkg::UDP_HDR_BYTES);
            n_out.payload_length = r_snap_ul - 16'(iucheck_pkg::UDP_HDR_BYTES);
            n_out.source_address = r_snap_src;
            n_out.source_port    = r_snap_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != iucheck_pkg::ST_OK)
            |-> (o_out_data.payload_offset == '0 && o_out_data.payload_length == '0
                 && o_out_data.source_address == '0 && o_out_data.source_port == '0))
        else $error("failed verdict carries nonzero fields");

    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == iucheck_pkg::ST_OK)
            |-> (o_out_data.payload_offset[1:0] == 2'b00
                 && o_out_data.payload_offset >= 7'(iucheck_pkg::UDP_HDR_BYTES)))
        else $error("good verdict with impossible payload offset");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_byte) |=> (r_pos == '0 && r_snap_valid))
        else $error("packet state not cleared after last byte");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_PACKET_BYTES))
        else $error("byte position beyond packet limit");

endmodule
